### hw/rtl/lcd4_pkg.sv
// Shared types, codes and constants for the 4-bit character LCD interface.
`timescale 1ns / 1ps
`default_nettype none

package lcd4_pkg;

    localparam logic [2:0] CMD_INIT       = 3'd0;
    localparam logic [2:0] CMD_WRITE_CHAR = 3'd1;
    localparam logic [2:0] CMD_WRITE_CMD  = 3'd2;
    localparam logic [2:0] CMD_GOTO       = 3'd3;
    localparam logic [2:0] CMD_CLEAR      = 3'd4;

    localparam logic CFG_BUSY_WAIT  = 1'b0;
    localparam logic CFG_CLEAR_WAIT = 1'b1;

    localparam logic [9:0]  BUSY_WAIT_RESET  = 10'd100;
    localparam logic [13:0] CLEAR_WAIT_RESET = 14'd2000;

    localparam logic [13:0] HOLD_MAX      = 14'd16383;
    localparam logic [13:0] POWER_ON_US   = 14'd15000;
    localparam logic [13:0] STROBE_US     = 14'd1;
    localparam logic [13:0] INIT_GAP_US   = 14'd40;
    localparam logic [13:0] GOTO_TAIL_US  = 14'd100;
    localparam logic [13:0] ENTRY_TAIL_US = 14'd1000;
    localparam logic [3:0]  INIT_NIBBLE   = 4'h2;
    localparam logic [7:0]  CLEAR_BYTE    = 8'h01;
    localparam logic [7:0]  FUNC_SET_BYTE = 8'h28;
    localparam logic [7:0]  DISP_ON_BYTE  = 8'h0C;
    localparam logic [7:0]  ENTRY_BYTE    = 8'h06;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic        init;
        logic        rs;
        logic [7:0]  data;
        logic [13:0] tail;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRE,
        ST_BYTE
    } t_back_state;

    function automatic logic [7:0] row_base(input logic [1:0] idx);
        logic [7:0] base;
        case (idx)
            2'd0:    base = 8'h80;
            2'd1:    base = 8'hC0;
            2'd2:    base = 8'h94;
            default: base = 8'hD4;
        endcase
        return base;
    endfunction

    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = FUNC_SET_BYTE;
            2'd1:    b = DISP_ON_BYTE;
            default: b = ENTRY_BYTE;
        endcase
        return b;
    endfunction

    function automatic logic [13:0] init_tail(input logic [1:0] idx);
        logic [13:0] t;
        case (idx)
            2'd0, 2'd1: t = INIT_GAP_US;
            default:    t = ENTRY_TAIL_US;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/lcd4_front.sv
// Request decoder: accepts requests and turns them into byte jobs for the queue.
`timescale 1ns / 1ps
`default_nettype none

module lcd4_front
    import lcd4_pkg::*;
(
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_command,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [2:0]  i_row,
    input  wire logic [5:0]  i_column,
    input  wire logic [13:0] i_clear_wait,
    input  wire logic        i_full,
    output logic             o_push,
    output t_job             o_job
);

    logic keep;
    logic [1:0] row_idx;

    assign o_ready = !i_full;
    assign row_idx = 2'(i_row - 3'd1);

    always_comb begin
        keep  = 1'b1;
        o_job = '{init: 1'b0, rs: 1'b0, data: i_data_byte, tail: '0};
        unique case (i_command)
            CMD_INIT: begin
                o_job.init = 1'b1;
            end
            CMD_WRITE_CHAR: begin
                o_job.rs = 1'b1;
            end
            CMD_WRITE_CMD: begin
            end
            CMD_GOTO: begin
                keep       = (i_row >= 3'd1) && (i_row <= 3'd4);
                o_job.data = row_base(row_idx) + {2'b00, i_column} + 8'hFF;
                o_job.tail = GOTO_TAIL_US;
            end
            CMD_CLEAR: begin
                o_job.data = CLEAR_BYTE;
                o_job.tail = i_clear_wait;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_push = i_valid && !i_full && keep;

endmodule

`default_nettype wire

### hw/rtl/lcd4_fifo.sv
// Short job queue between the request decoder and the pin sequencer.
`timescale 1ns / 1ps
`default_nettype none

module lcd4_fifo
    import lcd4_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lcd4_back.sv
// Pin sequencer: plays each queued job out as a series of LCD bus states.
`timescale 1ns / 1ps
`default_nettype none

module lcd4_back
    import lcd4_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [9:0]  i_busy_wait,
    input  wire logic        i_empty,
    input  wire t_job        i_job,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_rs,
    output logic             o_enable,
    output logic [3:0]       o_nibble,
    output logic [13:0]      o_hold_us,
    output logic             o_last
);

    t_back_state r_state, n_state;
    t_job        r_job, n_job;
    logic [2:0]  r_sub, n_sub;
    logic [1:0]  r_idx, n_idx;

    logic        r_out_valid;
    logic        r_rs, r_enable, r_last;
    logic [3:0]  r_nibble;
    logic [13:0] r_hold;

    logic        adv, step, load;
    logic        res_rs, res_enable, res_last;
    logic [3:0]  res_nibble;
    logic [13:0] res_hold;
    logic [7:0]  cur_byte;
    logic [13:0] cur_tail;
    logic [14:0] tail_sum;

    assign adv  = !r_out_valid || i_ready;
    assign step = adv && (r_state != ST_IDLE);
    assign load = ((r_state == ST_IDLE) || (step && res_last)) && !i_empty;
    assign o_pop = load;

    assign cur_byte = r_job.init ? init_byte(r_idx) : r_job.data;
    assign cur_tail = r_job.init ? init_tail(r_idx) : r_job.tail;
    assign tail_sum = {1'b0, cur_tail} + 15'd1;

    always_comb begin
        res_rs     = r_job.rs;
        res_enable = 1'b0;
        res_nibble = INIT_NIBBLE;
        res_hold   = STROBE_US;
        res_last   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_PRE: begin
                res_rs = 1'b0;
                case (r_sub)
                    3'd0:    res_hold = POWER_ON_US;
                    3'd1:    res_enable = 1'b1;
                    default: res_hold = INIT_GAP_US;
                endcase
            end
            ST_BYTE: begin
                res_nibble = (r_sub < 3'd3) ? cur_byte[7:4] : cur_byte[3:0];
                res_enable = (r_sub == 3'd1) || (r_sub == 3'd3);
                case (r_sub)
                    3'd0: res_hold = {4'b0000, i_busy_wait};
                    3'd4: begin
                        res_hold = tail_sum[14] ? HOLD_MAX : tail_sum[13:0];
                        res_last = !r_job.init || (r_idx == 2'd2);
                    end
                    default: res_hold = STROBE_US;
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_sub   = r_sub;
        n_idx   = r_idx;
        if (load) begin
            n_job   = i_job;
            n_sub   = '0;
            n_idx   = '0;
            n_state = i_job.init ? ST_PRE : ST_BYTE;
        end else if (step) begin
            if (res_last) begin
                n_state = ST_IDLE;
            end else if (r_state == ST_PRE) begin
                if (r_sub == 3'd2) begin
                    n_state = ST_BYTE;
                    n_sub   = '0;
                end else begin
                    n_sub = r_sub + 3'd1;
                end
            end else if (r_sub == 3'd4) begin
                n_sub = '0;
                n_idx = r_idx + 2'd1;
            end else begin
                n_sub = r_sub + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sub       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sub   <= n_sub;
            r_idx   <= n_idx;
            if (adv) begin
                r_out_valid <= step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        if (adv) begin
            r_rs     <= res_rs;
            r_enable <= res_enable;
            r_nibble <= res_nibble;
            r_hold   <= res_hold;
            r_last   <= res_last;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_rs      = r_rs;
    assign o_enable  = r_enable;
    assign o_nibble  = r_nibble;
    assign o_hold_us = r_hold;
    assign o_last    = r_last;

endmodule

`default_nettype wire

### hw/rtl/char_lcd_4bit_interface.sv
// Top level of the 4-bit character LCD interface: config registers, decoder, queue, sequencer.
//
// Each request transaction on the slave stream becomes a run of LCD bus pin states on the
// master stream, the final one marked by tlast. A request is taken whenever the four-entry
// job queue has room, so requests can arrive back to back while earlier ones are still
// being played out. The sequencer emits one pin state per cycle while the master side
// accepts, and moves to the next queued job without a gap: a byte write, go-to or clear is
// 5 pin states and init is 18. Go-to requests with a row outside 1 to 4 and unknown command
// codes are accepted and produce no output.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_4bit_interface
    import lcd4_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // command[2:0], data_byte[10:3], row[13:11], column[19:14], zero fill[23:20]
    input  wire logic [23:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // enable[0], nibble[4:1], hold_us[18:5], zero fill[23:19]
    output logic [23:0]      m_axis_tdata,
    // rs[0]
    output logic             m_axis_tuser,
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [13:0] i_cfg_data
);

    logic [9:0]  r_busy_wait;
    logic [13:0] r_clear_wait;

    logic        full, empty, push, pop;
    t_job        push_job, pop_job;
    logic        out_enable;
    logic [3:0]  out_nibble;
    logic [13:0] out_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_wait  <= BUSY_WAIT_RESET;
            r_clear_wait <= CLEAR_WAIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BUSY_WAIT:  r_busy_wait  <= i_cfg_data[9:0];
                CFG_CLEAR_WAIT: r_clear_wait <= i_cfg_data;
                default:        r_clear_wait <= r_clear_wait;
            endcase
        end
    end

    lcd4_front u_front (
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_command    (s_axis_tdata[2:0]),
        .i_data_byte  (s_axis_tdata[10:3]),
        .i_row        (s_axis_tdata[13:11]),
        .i_column     (s_axis_tdata[19:14]),
        .i_clear_wait (r_clear_wait),
        .i_full       (full),
        .o_push       (push),
        .o_job        (push_job)
    );

    lcd4_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_empty (empty)
    );

    lcd4_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_busy_wait (r_busy_wait),
        .i_empty     (empty),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_rs        (m_axis_tuser),
        .o_enable    (out_enable),
        .o_nibble    (out_nibble),
        .o_hold_us   (out_hold),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b00000, out_hold, out_nibble, out_enable};

endmodule

`default_nettype wire

### sim/tb_char_lcd_4bit_interface.sv
// Self-checking testbench for the 4-bit character LCD interface.
`timescale 1ns / 1ps
`default_nettype none

module tb_char_lcd_4bit_interface;
    import lcd4_pkg::*;

    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int HOLD_OFF_LEN  = 400;
    localparam int PHASE_ITEMS   = 25;
    localparam int IDLE_PCT      = 8;

    typedef struct packed {
        logic        rs;
        logic        en;
        logic [3:0]  nib;
        logic [13:0] hold;
        logic        is_last;
    } t_pin_state;

    class lcd_scoreboard;
        logic [9:0]  busy_wait_us;
        logic [13:0] clear_wait_us;
        t_pin_state  pin_states_q[$];
        int          mismatches;

        function new();
            busy_wait_us  = BUSY_WAIT_RESET;
            clear_wait_us = CLEAR_WAIT_RESET;
            mismatches    = 0;
        endfunction

        function void set_reg(logic idx, logic [13:0] value);
            if (idx == CFG_BUSY_WAIT) begin
                busy_wait_us = value[9:0];
            end else begin
                clear_wait_us = value;
            end
        endfunction

        function int pending();
            return pin_states_q.size();
        endfunction

        function void push_state(logic rs, logic en, logic [3:0] nib, int hold_us);
            t_pin_state s;
            s.rs      = rs;
            s.en      = en;
            s.nib     = nib;
            s.hold    = (hold_us > int'(HOLD_MAX)) ? HOLD_MAX : hold_us[13:0];
            s.is_last = 1'b0;
            pin_states_q.push_back(s);
        endfunction

        function void push_byte(logic rs, logic [7:0] b, int tail_us);
            push_state(rs, 1'b0, b[7:4], int'(busy_wait_us));
            push_state(rs, 1'b1, b[7:4], 1);
            push_state(rs, 1'b0, b[7:4], 1);
            push_state(rs, 1'b1, b[3:0], 1);
            push_state(rs, 1'b0, b[3:0], 1 + tail_us);
        endfunction

        function void note_request(logic [2:0] cmd, logic [7:0] data_byte, logic [2:0] row,
                                   logic [5:0] column);
            int         first;
            logic [7:0] base;
            logic [7:0] addr;
            t_pin_state s;
            first = pin_states_q.size();
            case (cmd)
                CMD_INIT: begin
                    push_state(1'b0, 1'b0, INIT_NIBBLE, 15000);
                    push_state(1'b0, 1'b1, INIT_NIBBLE, 1);
                    push_state(1'b0, 1'b0, INIT_NIBBLE, 40);
                    push_byte(1'b0, 8'h28, 40);
                    push_byte(1'b0, 8'h0C, 40);
                    push_byte(1'b0, 8'h06, 1000);
                end
                CMD_WRITE_CHAR: push_byte(1'b1, data_byte, 0);
                CMD_WRITE_CMD:  push_byte(1'b0, data_byte, 0);
                CMD_GOTO: begin
                    if (row >= 3'd1 && row <= 3'd4) begin
                        case (row)
                            3'd1:    base = 8'h80;
                            3'd2:    base = 8'hC0;
                            3'd3:    base = 8'h94;
                            default: base = 8'hD4;
                        endcase
                        addr = base + {2'b00, column} - 8'd1;
                        push_byte(1'b0, addr, 100);
                    end
                end
                CMD_CLEAR: push_byte(1'b0, 8'h01, int'(clear_wait_us));
                default: ;
            endcase
            if (pin_states_q.size() > first) begin
                s = pin_states_q.pop_back();
                s.is_last = 1'b1;
                pin_states_q.push_back(s);
            end
        endfunction

        function void report(string what, t_pin_state exp_s, t_pin_state got_s);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: %s: expected rs=%0d e=%0d nib=%h hold=%0d last=%0d",
                         $time, what, exp_s.rs, exp_s.en, exp_s.nib, exp_s.hold,
                         exp_s.is_last,
                         ", got rs=%0d e=%0d nib=%h hold=%0d last=%0d",
                         got_s.rs, got_s.en, got_s.nib, got_s.hold, got_s.is_last);
            end
        endfunction

        function void check_state(t_pin_state got_s);
            t_pin_state exp_s;
            if (pin_states_q.size() == 0) begin
                report("unexpected pin state", '0, got_s);
                return;
            end
            exp_s = pin_states_q.pop_front();
            if (got_s.rs !== exp_s.rs || got_s.en !== exp_s.en || got_s.nib !== exp_s.nib
                || got_s.hold !== exp_s.hold || got_s.is_last !== exp_s.is_last) begin
                report("pin state mismatch", exp_s, got_s);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [13:0] i_cfg_data;

    lcd_scoreboard sb;
    bit            quiet;
    int            rx_hold_len;
    int            cycle_count;

    char_lcd_4bit_interface u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Output side: random back-pressure plus an occasional long hold-off.
    initial begin
        t_pin_state got_s;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got_s.rs      = m_axis_tuser;
                got_s.en      = m_axis_tdata[0];
                got_s.nib     = m_axis_tdata[4:1];
                got_s.hold    = m_axis_tdata[18:5];
                got_s.is_last = m_axis_tlast;
                sb.check_state(got_s);
            end
            @(negedge i_clk);
            if (rx_hold_len > 0) begin
                m_axis_tready = 1'b0;
                rx_hold_len--;
            end else begin
                m_axis_tready = quiet || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    task automatic drive_request(logic [2:0] cmd, logic [7:0] data_byte, logic [2:0] row,
                                 logic [5:0] column);
        @(negedge i_clk);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  = {4'b0000, column, row, data_byte, cmd};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(cmd, data_byte, row, column);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [13:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(posedge i_clk);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Mostly well-formed requests; about one in ten is a code or row that the block drops.
    task automatic random_request(output bit useful);
        logic [2:0] cmd;
        logic [7:0] data_byte;
        logic [2:0] row;
        logic [5:0] column;
        int         pick;
        pick      = $urandom_range(0, 99);
        data_byte = 8'($urandom_range(0, 255));
        row       = 3'($urandom_range(1, 4));
        column    = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(1, 40));
        useful    = 1'b1;
        if (pick < 8) begin
            cmd = CMD_INIT;
        end else if (pick < 38) begin
            cmd = CMD_WRITE_CHAR;
        end else if (pick < 58) begin
            cmd = CMD_WRITE_CMD;
        end else if (pick < 80) begin
            cmd = CMD_GOTO;
        end else if (pick < 90) begin
            cmd = CMD_CLEAR;
        end else if (pick < 95) begin
            cmd    = CMD_GOTO;
            row    = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(5, 7));
            useful = 1'b0;
        end else begin
            cmd    = 3'($urandom_range(5, 7));
            useful = 1'b0;
        end
        if (cmd != CMD_GOTO && $urandom_range(0, 1) == 0) begin
            row = 3'($urandom_range(0, 7));
        end
        drive_request(cmd, data_byte, row, column);
    endtask

    initial begin
        bit          useful;
        int          sent;
        logic [9:0]  busy_val;
        logic [13:0] clear_val;
        sb            = new();
        quiet         = 1'b0;
        rx_hold_len   = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_BUSY_WAIT;
        i_cfg_data    = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        drive_request(CMD_INIT, 8'h00, 3'd0, 6'd0);
        drive_request(CMD_WRITE_CHAR, 8'h00, 3'd7, 6'd63);
        drive_request(CMD_WRITE_CHAR, 8'hFF, 3'd0, 6'd0);
        drive_request(CMD_WRITE_CHAR, 8'hA5, 3'd2, 6'd21);
        drive_request(CMD_WRITE_CMD, 8'h00, 3'd5, 6'd42);
        drive_request(CMD_WRITE_CMD, 8'hFF, 3'd1, 6'd1);
        drive_request(CMD_WRITE_CMD, 8'h5A, 3'd6, 6'd7);
        drive_request(CMD_GOTO, 8'h00, 3'd1, 6'd1);
        drive_request(CMD_GOTO, 8'hFF, 3'd4, 6'd40);
        drive_request(CMD_GOTO, 8'h3C, 3'd2, 6'd0);
        drive_request(CMD_GOTO, 8'hC3, 3'd3, 6'd63);
        drive_request(CMD_GOTO, 8'h81, 3'd4, 6'd63);
        drive_request(CMD_GOTO, 8'h11, 3'd0, 6'd5);
        drive_request(CMD_GOTO, 8'h22, 3'd5, 6'd10);
        drive_request(CMD_GOTO, 8'h44, 3'd7, 6'd20);
        drive_request(CMD_CLEAR, 8'h99, 3'd3, 6'd33);
        drive_request(3'd5, 8'hF0, 3'd1, 6'd2);
        drive_request(3'd6, 8'h0F, 3'd2, 6'd3);
        drive_request(3'd7, 8'hAA, 3'd4, 6'd60);
        drive_request(CMD_WRITE_CHAR, 8'h41, 3'd1, 6'd12);

        for (int phase = 0; phase < 5; phase++) begin
            drain_results();
            case (phase)
                0: begin busy_val = 10'd0;    clear_val = 14'd0;     end
                1: begin busy_val = 10'd1023; clear_val = 14'd16383; end
                2: begin busy_val = 10'd1023; clear_val = 14'd16382; end
                3: begin
                    busy_val  = 10'($urandom_range(0, 1023));
                    clear_val = 14'($urandom_range(0, 16383));
                end
                default: begin busy_val = BUSY_WAIT_RESET; clear_val = CLEAR_WAIT_RESET; end
            endcase
            write_reg(CFG_BUSY_WAIT, {4'b0000, busy_val});
            write_reg(CFG_CLEAR_WAIT, clear_val);
            quiet = (phase == 2);
            if (phase == 1 || phase == 3) begin
                rx_hold_len = HOLD_OFF_LEN;
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                random_request(useful);
                if (useful) begin
                    sent++;
                end
            end
        end

        quiet = 1'b0;
        drain_results();
        if (sb.pending() > 0) begin
            $display("%0d pin states never arrived", sb.pending());
            sb.mismatches++;
        end
        if (sb.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
